@@ rtl/wsfd_pkg.sv @@
package wsfd_pkg;

   typedef enum logic [2:0] {
      PH_HDR0    = 3'd0,
      PH_HDR1    = 3'd1,
      PH_EXT16   = 3'd2,
      PH_EXT64   = 3'd3,
      PH_MASK    = 3'd4,
      PH_PAYLOAD = 3'd5
   } phase_type;

   localparam logic [3:0] OP_CONT   = 4'h0;
   localparam logic [3:0] OP_TEXT   = 4'h1;
   localparam logic [3:0] OP_BINARY = 4'h2;
   localparam logic [3:0] OP_CLOSE  = 4'h8;
   localparam logic [3:0] OP_PING   = 4'h9;
   localparam logic [3:0] OP_PONG   = 4'hA;

   localparam logic [2:0] KIND_DATA       = 3'd0;
   localparam logic [2:0] KIND_PING_DATA  = 3'd1;
   localparam logic [2:0] KIND_EMPTY_PING = 3'd2;
   localparam logic [2:0] KIND_CLOSE      = 3'd3;
   localparam logic [2:0] KIND_BAD_OPCODE = 3'd4;
   localparam logic [2:0] KIND_OVERSIZE   = 3'd5;

   localparam int LEN_W = 25;

   localparam logic [LEN_W-1:0] MAX_LEN_RESET = 25'd4194304;
   localparam logic [6:0]       CODE_EXT16    = 7'd126;
   localparam logic [6:0]       CODE_EXT64    = 7'd127;
   localparam logic [2:0]       EXT16_LAST    = 3'd1;
   localparam logic [2:0]       EXT64_LAST    = 3'd7;
   localparam logic [2:0]       MASK_LAST     = 3'd3;

endpackage

@@ rtl/websocket_frame_deframer_top.sv @@
// A request that gives a result shows it on rsp_valid in the cycle after acceptance.
// Throughput: one received byte per cycle while req_stall is low; the header parser
// and unmasking sit in a single combinational pass between the parser state registers
// and the result register. A request is refused only while it is full and stalled.
// Reset (synchronous, active high) returns the parser to the first header byte,
// clears the halt, empties the result register and sets the length limit to 4194304.
module websocket_frame_deframer_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_data_byte,
   output logic [2:0]  rsp_kind,
   output logic        rsp_last,
   input  logic        csr_wr_en,
   input  logic [24:0] csr_wr_data
);

   wsfd_pkg::phase_type phase_ff, phase_in;
   logic [3:0]                 opcode_ff, opcode_in;
   logic                       mask_ff, mask_in;
   logic [2:0]                 cnt_ff, cnt_in;
   logic [wsfd_pkg::LEN_W-1:0] len_ff, len_in;
   logic                       ovf_ff, ovf_in;
   logic [31:0]                key_ff, key_in;
   logic [wsfd_pkg::LEN_W-1:0] idx_ff, idx_in;
   logic                       halted_ff, halted_in;
   logic [wsfd_pkg::LEN_W-1:0] max_len_ff;

   logic                       rsp_valid_ff;
   logic [7:0]                 rsp_data_ff;
   logic [2:0]                 rsp_kind_ff;
   logic                       rsp_last_ff;

   logic                       fire;
   logic [6:0]                 code;
   logic                       code_short;
   logic [wsfd_pkg::LEN_W-1:0] len_cur;
   logic                       ovf_cur;
   logic                       ext_done;
   logic                       len_known;
   logic                       oversize;
   logic                       mask_now;
   logic                       mask_done;
   logic                       start_pl;
   logic [wsfd_pkg::LEN_W-1:0] len_start;
   logic                       start_empty;
   logic [wsfd_pkg::LEN_W-1:0] idx_next;
   logic                       pl_end;
   logic                       finish;
   logic                       op_fatal;
   logic                       op_data;
   logic [7:0]                 key_byte;
   logic [7:0]                 unmasked;

   logic                       res_valid;
   logic [7:0]                 res_data;
   logic [2:0]                 res_kind;
   logic                       res_last;
   logic                       res_load;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign fire      = req_valid && !req_stall;

   // Header decode shared by the state update and the result logic.
   always_comb begin
      code       = req_rx_byte[6:0];
      code_short = (code != wsfd_pkg::CODE_EXT16) && (code != wsfd_pkg::CODE_EXT64);
      ext_done   = ((phase_ff == wsfd_pkg::PH_EXT16) && (cnt_ff == wsfd_pkg::EXT16_LAST)) ||
                   ((phase_ff == wsfd_pkg::PH_EXT64) && (cnt_ff == wsfd_pkg::EXT64_LAST));
      // Only the low 25 bits of the length are kept; anything shifted above them
      // can only make the frame oversize, so a sticky flag records it.
      if (phase_ff == wsfd_pkg::PH_HDR1) begin
         len_cur = {{(wsfd_pkg::LEN_W-7){1'b0}}, code};
         ovf_cur = 1'b0;
      end else begin
         len_cur = {len_ff[wsfd_pkg::LEN_W-9:0], req_rx_byte};
         ovf_cur = ovf_ff || (|len_ff[wsfd_pkg::LEN_W-1:wsfd_pkg::LEN_W-8]);
      end
      len_known = ((phase_ff == wsfd_pkg::PH_HDR1) && code_short) || ext_done;
      oversize  = len_known && (ovf_cur || (len_cur > max_len_ff));
      mask_now  = (phase_ff == wsfd_pkg::PH_HDR1) ? req_rx_byte[7] : mask_ff;
      mask_done = (phase_ff == wsfd_pkg::PH_MASK) && (cnt_ff == wsfd_pkg::MASK_LAST);
      start_pl  = (len_known && !oversize && !mask_now) || mask_done;
      len_start = mask_done ? len_ff : len_cur;
      start_empty = start_pl && (len_start == '0);
      idx_next  = idx_ff + 1'b1;
      pl_end    = (phase_ff == wsfd_pkg::PH_PAYLOAD) && (idx_next == len_ff);
      finish    = start_empty || pl_end;
      case (opcode_ff) inside
         wsfd_pkg::OP_CONT, wsfd_pkg::OP_TEXT, wsfd_pkg::OP_BINARY,
         wsfd_pkg::OP_PING, wsfd_pkg::OP_PONG: op_fatal = 1'b0;
         default:                              op_fatal = 1'b1;
      endcase
      op_data   = (opcode_ff == wsfd_pkg::OP_CONT) || (opcode_ff == wsfd_pkg::OP_BINARY);
      case (idx_ff[1:0])
         2'd0:    key_byte = key_ff[31:24];
         2'd1:    key_byte = key_ff[23:16];
         2'd2:    key_byte = key_ff[15:8];
         default: key_byte = key_ff[7:0];
      endcase
      unmasked  = mask_ff ? (req_rx_byte ^ key_byte) : req_rx_byte;
   end

   // Next state of the parser.
   always_comb begin
      phase_in = phase_ff;
      if (fire && !halted_ff) begin
         unique case (phase_ff)
            wsfd_pkg::PH_HDR0: phase_in = wsfd_pkg::PH_HDR1;
            wsfd_pkg::PH_HDR1: begin
               if (code == wsfd_pkg::CODE_EXT16) begin
                  phase_in = wsfd_pkg::PH_EXT16;
               end else if (code == wsfd_pkg::CODE_EXT64) begin
                  phase_in = wsfd_pkg::PH_EXT64;
               end else if (!oversize && mask_now) begin
                  phase_in = wsfd_pkg::PH_MASK;
               end else if (start_pl) begin
                  phase_in = start_empty ? wsfd_pkg::PH_HDR0 : wsfd_pkg::PH_PAYLOAD;
               end
            end
            wsfd_pkg::PH_EXT16, wsfd_pkg::PH_EXT64: begin
               if (ext_done && !oversize) begin
                  if (mask_now) begin
                     phase_in = wsfd_pkg::PH_MASK;
                  end else begin
                     phase_in = start_empty ? wsfd_pkg::PH_HDR0 : wsfd_pkg::PH_PAYLOAD;
                  end
               end
            end
            wsfd_pkg::PH_MASK: begin
               if (mask_done) begin
                  phase_in = start_empty ? wsfd_pkg::PH_HDR0 : wsfd_pkg::PH_PAYLOAD;
               end
            end
            wsfd_pkg::PH_PAYLOAD: begin
               if (pl_end) begin
                  phase_in = wsfd_pkg::PH_HDR0;
               end
            end
            default: phase_in = wsfd_pkg::PH_HDR0;
         endcase
      end
   end

   // Datapath registers and the result of the current request.
   always_comb begin
      opcode_in = opcode_ff;
      mask_in   = mask_ff;
      cnt_in    = cnt_ff;
      len_in    = len_ff;
      ovf_in    = ovf_ff;
      key_in    = key_ff;
      idx_in    = idx_ff;
      halted_in = halted_ff;
      res_valid = 1'b0;
      res_data  = 8'd0;
      res_kind  = wsfd_pkg::KIND_DATA;
      res_last  = 1'b1;
      if (fire && !halted_ff) begin
         case (phase_ff)
            wsfd_pkg::PH_HDR0: opcode_in = req_rx_byte[3:0];
            wsfd_pkg::PH_HDR1: begin
               mask_in = req_rx_byte[7];
               key_in  = 32'd0;
               cnt_in  = 3'd0;
               len_in  = code_short ? len_cur : '0;
               ovf_in  = 1'b0;
            end
            wsfd_pkg::PH_EXT16, wsfd_pkg::PH_EXT64: begin
               len_in = len_cur;
               ovf_in = ovf_cur;
               cnt_in = ext_done ? 3'd0 : cnt_ff + 3'd1;
            end
            wsfd_pkg::PH_MASK: begin
               key_in = {key_ff[23:0], req_rx_byte};
               cnt_in = cnt_ff + 3'd1;
            end
            wsfd_pkg::PH_PAYLOAD: idx_in = idx_next;
            default: ;
         endcase
         if (start_pl) begin
            idx_in = '0;
         end

         if (oversize) begin
            halted_in = 1'b1;
            res_valid = 1'b1;
            res_kind  = wsfd_pkg::KIND_OVERSIZE;
         end else if (finish && (opcode_ff == wsfd_pkg::OP_CLOSE)) begin
            halted_in = 1'b1;
            res_valid = 1'b1;
            res_kind  = wsfd_pkg::KIND_CLOSE;
         end else if (finish && op_fatal) begin
            halted_in = 1'b1;
            res_valid = 1'b1;
            res_kind  = wsfd_pkg::KIND_BAD_OPCODE;
         end else if (start_empty && (opcode_ff == wsfd_pkg::OP_PING)) begin
            res_valid = 1'b1;
            res_kind  = wsfd_pkg::KIND_EMPTY_PING;
         end else if (phase_ff == wsfd_pkg::PH_PAYLOAD) begin
            res_data = unmasked;
            res_last = pl_end;
            if (op_data) begin
               res_valid = 1'b1;
               res_kind  = wsfd_pkg::KIND_DATA;
            end else if (opcode_ff == wsfd_pkg::OP_PING) begin
               res_valid = 1'b1;
               res_kind  = wsfd_pkg::KIND_PING_DATA;
            end
         end
      end
   end

   assign res_load = fire && res_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= wsfd_pkg::PH_HDR0;
         opcode_ff    <= 4'd0;
         mask_ff      <= 1'b0;
         cnt_ff       <= 3'd0;
         len_ff       <= '0;
         ovf_ff       <= 1'b0;
         key_ff       <= 32'd0;
         idx_ff       <= '0;
         halted_ff    <= 1'b0;
         max_len_ff   <= wsfd_pkg::MAX_LEN_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         opcode_ff <= opcode_in;
         mask_ff   <= mask_in;
         cnt_ff    <= cnt_in;
         len_ff    <= len_in;
         ovf_ff    <= ovf_in;
         key_ff    <= key_in;
         idx_ff    <= idx_in;
         halted_ff <= halted_in;
         if (csr_wr_en) begin
            max_len_ff <= csr_wr_data;
         end
         if (res_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (res_load) begin
         rsp_data_ff <= res_data;
         rsp_kind_ff <= res_kind;
         rsp_last_ff <= res_last;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_data_byte = rsp_data_ff;
   assign rsp_kind      = rsp_kind_ff;
   assign rsp_last      = rsp_last_ff;

`ifndef SYNTHESIS
   a_halted_silent: assert property (@(posedge clock) disable iff (reset)
      halted_ff |-> !res_load)
      else $error("result produced while halted");

   a_events_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_kind_ff == wsfd_pkg::KIND_EMPTY_PING ||
                        rsp_kind_ff == wsfd_pkg::KIND_CLOSE ||
                        rsp_kind_ff == wsfd_pkg::KIND_BAD_OPCODE ||
                        rsp_kind_ff == wsfd_pkg::KIND_OVERSIZE)) |-> rsp_last_ff)
      else $error("event result without last");

   a_payload_bound: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == wsfd_pkg::PH_PAYLOAD && !halted_ff) |-> (!ovf_ff && idx_ff < len_ff))
      else $error("payload index beyond frame length");

   a_halt_holds: assert property (@(posedge clock) disable iff (reset)
      halted_ff |=> halted_ff)
      else $error("halt released without reset");
`endif

endmodule
